[design/bsa_pkg.sv]
package bsa_pkg;

	localparam int unsigned DATA_W = 32;

	// One input item: an element and the end-of-block flag.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_item_t;

	// One result item: the next element in ascending order.
	typedef struct packed {
		logic signed [DATA_W-1:0] value_res;
		logic                     last_res;
	} out_item_t;

	typedef enum logic [0:0] {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		cell_op_t op;
	} cell_cmd_t;

endpackage

[design/bsa_cell.sv]
// One slot of the sorted chain. On insert it keeps its element, takes the new
// one, or takes its left neighbor's; on shift it takes its right neighbor's.
module bsa_cell (
	input  logic                              clk,
	input  bsa_pkg::cell_cmd_t                cmd,
	input  logic                              occupied,
	input  logic signed [bsa_pkg::DATA_W-1:0] new_value,
	input  logic signed [bsa_pkg::DATA_W-1:0] left_value,
	input  logic                              left_gt,
	input  logic signed [bsa_pkg::DATA_W-1:0] right_value,
	output logic signed [bsa_pkg::DATA_W-1:0] value,
	output logic                              gt
);

	logic signed [bsa_pkg::DATA_W-1:0] value_q;

	// Empty slots count as larger than anything, so a new element lands there.
	assign gt    = !occupied || (value_q > new_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			bsa_pkg::CELL_INSERT: begin
				if (gt) begin
					value_q <= left_gt ? left_value : new_value;
				end
			end
			bsa_pkg::CELL_SHIFT: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

[design/bsa_ctrl.sv]
// Fill count, drain count and load/drain sequencing.
module bsa_ctrl #(
	parameter int unsigned BLOCK_SIZE = 32,
	parameter int unsigned CW         = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	input  logic               out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output logic               last_res,
	output logic [CW-1:0]      fill,
	output bsa_pkg::cell_cmd_t cmd
);

	bsa_pkg::state_t state_q, state_d;
	logic [CW-1:0]   fill_q, fill_d;
	logic [CW-1:0]   remain_q, remain_d;
	logic [CW-1:0]   count;
	logic            in_acc;
	logic            out_acc;

	assign fill = fill_q;
	assign count = fill_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bsa_pkg::ST_LOAD;
			fill_q   <= '0;
			remain_q <= '0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			remain_q <= remain_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		remain_d = remain_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		last_res  = (remain_q == CW'(1));
		cmd.op    = bsa_pkg::CELL_HOLD;
		in_acc    = 1'b0;
		out_acc   = 1'b0;
		case (state_q)
			bsa_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				in_acc   = in_valid;
				if (in_acc) begin
					cmd.op = bsa_pkg::CELL_INSERT;
					// Block closes on last or when the chain is full.
					if (in_last || (count == CW'(BLOCK_SIZE))) begin
						remain_d = count;
						fill_d   = '0;
						state_d  = bsa_pkg::ST_DRAIN;
					end else begin
						fill_d = count;
					end
				end
			end
			bsa_pkg::ST_DRAIN: begin
				out_valid = 1'b1;
				out_acc   = out_ready;
				if (out_acc) begin
					cmd.op   = bsa_pkg::CELL_SHIFT;
					remain_d = remain_q - CW'(1);
					if (remain_q == CW'(1)) begin
						state_d = bsa_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				state_d = bsa_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

[design/block_sorter_ascending_unit.sv]
// channel | handshake            | payload
// --------+----------------------+----------------------------------------
// in      | in_valid / in_ready  | in_item  : value (s32), last
// out     | out_valid / out_ready| out_item : value_res (s32), last_res
//
// Load: one item per cycle; each one is inserted into a sorted chain of
// BLOCK_SIZE cells in the cycle it is accepted (a compare in every cell).
// Drain: the block leaves from cell 0, one item per cycle while out_ready is
// high; in_ready is low throughout the drain.
// Reset clears the fill count and the sequencer; cell contents are not reset.
// out_ready low holds the chain, so the shown item stays put.
module block_sorter_ascending_unit #(
	parameter int unsigned BLOCK_SIZE = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bsa_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output bsa_pkg::out_item_t out_item
);

	// Count must hold BLOCK_SIZE itself.
	localparam int unsigned CW = $clog2(BLOCK_SIZE + 1);

	logic [CW-1:0]                     fill;
	logic                              last_res;
	bsa_pkg::cell_cmd_t                cmd;
	logic signed [bsa_pkg::DATA_W-1:0] cell_value [BLOCK_SIZE];
	logic                              cell_gt    [BLOCK_SIZE];

	bsa_ctrl #(
		.BLOCK_SIZE (BLOCK_SIZE),
		.CW         (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_item.last),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.last_res  (last_res),
		.fill      (fill),
		.cmd       (cmd)
	);

	// Chain kept ascending from cell 0; duplicates land after their equals.
	for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
		logic signed [bsa_pkg::DATA_W-1:0] left_value;
		logic                              left_gt;
		logic signed [bsa_pkg::DATA_W-1:0] right_value;

		if (i == 0) begin : g_head
			// Nothing to the left: the head takes the new item when it moves.
			assign left_value = in_item.value;
			assign left_gt    = 1'b0;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_gt    = cell_gt[i-1];
		end

		if (i == BLOCK_SIZE - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_mid
			assign right_value = cell_value[i+1];
		end

		bsa_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (CW'(i) < fill),
			.new_value   (in_item.value),
			.left_value  (left_value),
			.left_gt     (left_gt),
			.right_value (right_value),
			.value       (cell_value[i]),
			.gt          (cell_gt[i])
		);
	end

	assign out_item.value_res = cell_value[0];
	assign out_item.last_res  = last_res;

endmodule

[design/bsa_checker.sv]
module bsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input bsa_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input bsa_pkg::out_item_t out_item
);

	// Loading and draining never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while draining");

	// An item marked last opens the drain in the next cycle.
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.last) |=> out_valid)
		else $error("no drain after last item");

	// The drain keeps going until the item flagged last_res leaves.
	a_drain_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_item.last_res) |=> out_valid)
		else $error("drain stopped early");

	// The block ends with last_res and the unit goes back to loading.
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.last_res) |=> (!out_valid && in_ready))
		else $error("drain did not end after last_res");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("stalled result changed");

endmodule

bind block_sorter_ascending_unit bsa_checker u_bsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
